@@ hdl/free_list_id_allocator_macros.svh @@
// ----------------------------------------------------------------------------
// Free list ID allocator assertion macros
// Shared property wrappers for the allocator checks.
// ----------------------------------------------------------------------------
`ifndef FREE_LIST_ID_ALLOCATOR_MACROS_SVH
`define FREE_LIST_ID_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define FLA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("free list allocator check failed");

// next-cycle implication
`define FLA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("free list allocator check failed");

`endif

@@ hdl/fla_pkg.sv @@
// ----------------------------------------------------------------------------
// Free list ID allocator package
// Widths, request and status codes, and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package fla_pkg;

   localparam int CAPACITY_DEF = 64;

   localparam int SIZE_W = 7;
   localparam int REQ_W  = 2;
   localparam int STAT_W = 2;
   localparam int ADDR_W = 2;
   localparam int DATA_W = 32;

   localparam logic [SIZE_W-1:0] INIT_SIZE_RST  = 7'd16;
   localparam logic [ADDR_W-1:0] ADDR_INIT_SIZE = 2'd0;

   localparam logic [REQ_W-1:0] REQ_ACQUIRE = 2'd0;
   localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_SHRINK  = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
   localparam logic [STAT_W-1:0] STAT_BAD_REL = 2'd2;
   localparam logic [STAT_W-1:0] STAT_NOTHING = 2'd3;

   typedef struct packed {
      logic live;
      logic free;
   } flag_type;

   typedef struct packed {
      logic              init;
      logic [SIZE_W-1:0] size;
   } cfg_type;

endpackage

`default_nettype wire

@@ hdl/free_list_id_allocator.sv @@
// ----------------------------------------------------------------------------
// Free list ID allocator
// Hands out, takes back and retires entry IDs from a LIFO free stack.
// ----------------------------------------------------------------------------
// The pool of IDs lives in two RAMs with registered reads: the free stack and a
// per-ID live/free flag table. Each request word yields exactly one response
// word. Acquire from a non-empty stack pops it (POP); release checks and pushes (REL).
// Acquire with an empty stack scans the flag RAM from ID 0 for the lowest
// unused ID, one read (SCAN) and one check (SCHK) per ID examined. Shrink
// retires N IDs, one stack read and one flag write per ID. Requests that change
// nothing (pool full, nothing to shrink, unused type) finish straight from idle.
// After reset and after every write of the initial pool size register the
// block rebuilds both RAMs, one entry per cycle over all CAPACITY entries;
// req_stall stays high during that sweep. A finished response waits in an output
// register, so the next request is taken while rsp_stall holds the last one.
// ----------------------------------------------------------------------------
`default_nettype none

`include "free_list_id_allocator_macros.svh"

module free_list_id_allocator #(
   parameter  int CAPACITY = fla_pkg::CAPACITY_DEF,
   localparam int ID_W     = $clog2(CAPACITY),
   localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [fla_pkg::ADDR_W-1:0]   csr_paddr,
   input  wire logic [fla_pkg::DATA_W-1:0]   csr_pwdata,
   output logic      [fla_pkg::DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [fla_pkg::REQ_W-1:0]    req_type,
   input  wire logic [ID_W-1:0]              req_item_id,
   input  wire logic [fla_pkg::SIZE_W-1:0]   req_target_size,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic      [ID_W-1:0]              rsp_granted_id,
   output logic      [fla_pkg::STAT_W-1:0]   rsp_status,
   output logic      [CNT_W-1:0]             rsp_retired_count,
   output logic      [CNT_W-1:0]             rsp_free_count,
   output logic      [CNT_W-1:0]             rsp_live_count
);

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   fla_pkg::cfg_type cfg;

   fla_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fla_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_item_id       (req_item_id),
      .req_target_size   (req_target_size),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_granted_id    (rsp_granted_id),
      .rsp_status        (rsp_status),
      .rsp_retired_count (rsp_retired_count),
      .rsp_free_count    (rsp_free_count),
      .rsp_live_count    (rsp_live_count)
   );

   `FLA_ASSERT_IMP(a_free_within_live, clock, reset, rsp_valid, rsp_free_count <= rsp_live_count)
   `FLA_ASSERT_IMP(a_full_exhausted, clock, reset, rsp_valid && rsp_status == fla_pkg::STAT_FULL, rsp_live_count == CAP_CNT && rsp_free_count == '0)
   `FLA_ASSERT_IMP(a_grant_only_ok, clock, reset, rsp_valid && rsp_granted_id != '0, rsp_status == fla_pkg::STAT_OK)
   `FLA_ASSERT_NEXT(a_write_blocks_req, clock, reset, csr_psel && csr_penable && csr_pwrite && csr_paddr == fla_pkg::ADDR_INIT_SIZE, req_stall)

endmodule

`default_nettype wire

@@ hdl/fla_ram.sv @@
// ----------------------------------------------------------------------------
// Free list ID allocator RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fla_ram #(
   parameter  int DEPTH = fla_pkg::CAPACITY_DEF,
   parameter  int WIDTH = 8,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ hdl/fla_csr.sv @@
// ----------------------------------------------------------------------------
// Free list ID allocator register block
// Holds the initial pool size and flags a pool rebuild on each write of it.
// ----------------------------------------------------------------------------
`default_nettype none

module fla_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [fla_pkg::ADDR_W-1:0]      csr_paddr,
   input  wire logic [fla_pkg::DATA_W-1:0]      csr_pwdata,
   output logic      [fla_pkg::DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready,
   output fla_pkg::cfg_type                     cfg
);

   logic                       size_wr;
   logic [fla_pkg::SIZE_W-1:0] size_ff;
   logic [fla_pkg::SIZE_W-1:0] size_in;
   logic                       init_ff;
   logic                       init_in;

   assign csr_pready = 1'b1;
   assign size_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == fla_pkg::ADDR_INIT_SIZE);
   assign size_in    = size_wr ? csr_pwdata[fla_pkg::SIZE_W-1:0] : size_ff;
   assign init_in    = size_wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= fla_pkg::INIT_SIZE_RST;
         init_ff <= 1'b0;
      end else begin
         size_ff <= size_in;
         init_ff <= init_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == fla_pkg::ADDR_INIT_SIZE) begin
         csr_prdata = fla_pkg::DATA_W'(size_ff);
      end
   end

   assign cfg.init = init_ff;
   assign cfg.size = size_ff;

endmodule

`default_nettype wire

@@ hdl/fla_ctrl.sv @@
// ----------------------------------------------------------------------------
// Free list ID allocator control
// Sequences pops, pushes, scans and retirements over the stack and flag RAMs.
// ----------------------------------------------------------------------------
`default_nettype none

module fla_ctrl #(
   parameter  int CAPACITY = fla_pkg::CAPACITY_DEF,
   localparam int ID_W     = $clog2(CAPACITY),
   localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire fla_pkg::cfg_type             cfg,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [fla_pkg::REQ_W-1:0]    req_type,
   input  wire logic [ID_W-1:0]              req_item_id,
   input  wire logic [fla_pkg::SIZE_W-1:0]   req_target_size,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic      [ID_W-1:0]              rsp_granted_id,
   output logic      [fla_pkg::STAT_W-1:0]   rsp_status,
   output logic      [CNT_W-1:0]             rsp_retired_count,
   output logic      [CNT_W-1:0]             rsp_free_count,
   output logic      [CNT_W-1:0]             rsp_live_count
);

   localparam int CMP_W = (CNT_W > fla_pkg::SIZE_W) ? CNT_W : fla_pkg::SIZE_W;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [ID_W-1:0]  LAST_ID = ID_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

   localparam logic [3:0] ST_INIT = 4'd0;
   localparam logic [3:0] ST_IDLE = 4'd1;
   localparam logic [3:0] ST_POP  = 4'd2;
   localparam logic [3:0] ST_SCAN = 4'd3;
   localparam logic [3:0] ST_SCHK = 4'd4;
   localparam logic [3:0] ST_REL  = 4'd5;
   localparam logic [3:0] ST_SHR  = 4'd6;
   localparam logic [3:0] ST_SHW  = 4'd7;
   localparam logic [3:0] ST_DONE = 4'd8;

   logic [3:0]                  state_ff,   state_in;
   logic [ID_W-1:0]             scan_ff,    scan_in;
   logic [CNT_W-1:0]            depth_ff,   depth_in;
   logic [CNT_W-1:0]            live_ff,    live_in;
   logic [ID_W-1:0]             id_ff,      id_in;
   logic                        id_ok_ff,   id_ok_in;
   logic [fla_pkg::SIZE_W-1:0]  target_ff,  target_in;
   logic [ID_W-1:0]             granted_ff, granted_in;
   logic [fla_pkg::STAT_W-1:0]  status_ff,  status_in;
   logic [CNT_W-1:0]            retired_ff, retired_in;

   logic                        rsp_valid_ff,   rsp_valid_in;
   logic [ID_W-1:0]             rsp_granted_ff, rsp_granted_in;
   logic [fla_pkg::STAT_W-1:0]  rsp_status_ff,  rsp_status_in;
   logic [CNT_W-1:0]            rsp_retired_ff, rsp_retired_in;
   logic [CNT_W-1:0]            rsp_free_ff,    rsp_free_in;
   logic [CNT_W-1:0]            rsp_live_ff,    rsp_live_in;

   logic                        fin;
   logic                        rsp_load;
   logic                        out_free;
   logic [CMP_W-1:0]            size_ext;
   logic [CNT_W-1:0]            init_n;

   logic                        stack_we;
   logic [ID_W-1:0]             stack_waddr;
   logic [ID_W-1:0]             stack_wdata;
   logic [ID_W-1:0]             stack_raddr;
   logic [ID_W-1:0]             stack_rdata;

   logic                        flag_we;
   logic [ID_W-1:0]             flag_waddr;
   fla_pkg::flag_type           flag_wdata;
   logic [ID_W-1:0]             flag_raddr;
   logic [$bits(fla_pkg::flag_type)-1:0] flag_rd_raw;
   fla_pkg::flag_type           flag_rd;

   fla_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (ID_W)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (stack_waddr),
      .wr_data (stack_wdata),
      .rd_addr (stack_raddr),
      .rd_data (stack_rdata)
   );

   fla_ram #(
      .DEPTH (CAPACITY),
      .WIDTH ($bits(fla_pkg::flag_type))
   ) u_flag_ram (
      .clock   (clock),
      .wr_en   (flag_we),
      .wr_addr (flag_waddr),
      .wr_data (flag_wdata),
      .rd_addr (flag_raddr),
      .rd_data (flag_rd_raw)
   );

   assign flag_rd   = fla_pkg::flag_type'(flag_rd_raw);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || cfg.init;
   assign size_ext  = CMP_W'(cfg.size);
   assign init_n    = (size_ext > CMP_W'(CAPACITY)) ? CAP_CNT : CNT_W'(size_ext);

   always_comb begin
      state_in    = state_ff;
      scan_in     = scan_ff;
      depth_in    = depth_ff;
      live_in     = live_ff;
      id_in       = id_ff;
      id_ok_in    = id_ok_ff;
      target_in   = target_ff;
      granted_in  = granted_ff;
      status_in   = status_ff;
      retired_in  = retired_ff;
      fin         = 1'b0;
      stack_we    = 1'b0;
      stack_waddr = ID_W'(depth_ff);
      stack_wdata = id_ff;
      stack_raddr = ID_W'(depth_ff - ONE_CNT);
      flag_we     = 1'b0;
      flag_waddr  = id_ff;
      flag_wdata  = '0;
      flag_raddr  = (state_ff == ST_IDLE) ? req_item_id : scan_ff;

      if (cfg.init) begin
         state_in = ST_INIT;
         scan_in  = '0;
      end else begin
         unique case (state_ff)
            ST_INIT: begin
               stack_we        = 1'b1;
               stack_waddr     = scan_ff;
               stack_wdata     = scan_ff;
               flag_we         = 1'b1;
               flag_waddr      = scan_ff;
               flag_wdata.live = CNT_W'(scan_ff) < init_n;
               flag_wdata.free = CNT_W'(scan_ff) < init_n;
               if (scan_ff == LAST_ID) begin
                  scan_in  = '0;
                  depth_in = init_n;
                  live_in  = init_n;
                  state_in = ST_IDLE;
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  granted_in = '0;
                  status_in  = fla_pkg::STAT_OK;
                  retired_in = '0;
                  id_in      = req_item_id;
                  id_ok_in   = CNT_W'(req_item_id) < CAP_CNT;
                  target_in  = req_target_size;
                  unique case (req_type)
                     fla_pkg::REQ_ACQUIRE: begin
                        if (depth_ff != '0) begin
                           state_in = ST_POP;
                        end else if (live_ff < CAP_CNT) begin
                           scan_in  = '0;
                           state_in = ST_SCAN;
                        end else begin
                           status_in = fla_pkg::STAT_FULL;
                           fin       = 1'b1;
                        end
                     end
                     fla_pkg::REQ_RELEASE: begin
                        state_in = ST_REL;
                     end
                     fla_pkg::REQ_SHRINK: begin
                        if (CMP_W'(req_target_size) < CMP_W'(live_ff)) begin
                           if (depth_ff == '0) begin
                              status_in = fla_pkg::STAT_NOTHING;
                              fin       = 1'b1;
                           end else begin
                              state_in = ST_SHR;
                           end
                        end else begin
                           fin = 1'b1;
                        end
                     end
                     default: begin
                        fin = 1'b1;
                     end
                  endcase
               end
            end
            ST_POP: begin
               granted_in      = stack_rdata;
               depth_in        = depth_ff - ONE_CNT;
               flag_we         = 1'b1;
               flag_waddr      = stack_rdata;
               flag_wdata.live = 1'b1;
               flag_wdata.free = 1'b0;
               fin             = 1'b1;
            end
            ST_SCAN: begin
               state_in = ST_SCHK;
            end
            ST_SCHK: begin
               if (!flag_rd.live) begin
                  flag_we         = 1'b1;
                  flag_waddr      = scan_ff;
                  flag_wdata.live = 1'b1;
                  flag_wdata.free = 1'b0;
                  live_in         = live_ff + ONE_CNT;
                  granted_in      = scan_ff;
                  fin             = 1'b1;
               end else begin
                  scan_in  = scan_ff + 1'b1;
                  state_in = ST_SCAN;
               end
            end
            ST_REL: begin
               if (id_ok_ff && flag_rd.live && !flag_rd.free && (depth_ff < CAP_CNT)) begin
                  flag_we         = 1'b1;
                  flag_waddr      = id_ff;
                  flag_wdata.live = 1'b1;
                  flag_wdata.free = 1'b1;
                  stack_we        = 1'b1;
                  depth_in        = depth_ff + ONE_CNT;
               end else begin
                  status_in = fla_pkg::STAT_BAD_REL;
               end
               fin = 1'b1;
            end
            ST_SHR: begin
               state_in = ST_SHW;
            end
            ST_SHW: begin
               flag_we    = 1'b1;
               flag_waddr = stack_rdata;
               flag_wdata = '0;
               depth_in   = depth_ff - ONE_CNT;
               live_in    = live_ff - ONE_CNT;
               retired_in = retired_ff + ONE_CNT;
               if ((CMP_W'(live_in) > CMP_W'(target_ff)) && (depth_in != '0)) begin
                  state_in = ST_SHR;
               end else begin
                  fin = 1'b1;
               end
            end
            ST_DONE: begin
               fin = 1'b1;
            end
            default: begin
               state_in = ST_INIT;
               scan_in  = '0;
            end
         endcase
         if (fin) begin
            state_in = out_free ? ST_IDLE : ST_DONE;
         end
      end
   end

   assign rsp_load = fin && out_free && !cfg.init;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_retired_in = rsp_retired_ff;
      rsp_free_in    = rsp_free_ff;
      rsp_live_in    = rsp_live_ff;
      if (rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_granted_in = granted_in;
         rsp_status_in  = status_in;
         rsp_retired_in = retired_in;
         rsp_free_in    = depth_in;
         rsp_live_in    = live_in;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         scan_ff      <= '0;
         depth_ff     <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         depth_ff     <= depth_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff          <= id_in;
      id_ok_ff       <= id_ok_in;
      target_ff      <= target_in;
      granted_ff     <= granted_in;
      status_ff      <= status_in;
      retired_ff     <= retired_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_retired_ff <= rsp_retired_in;
      rsp_free_ff    <= rsp_free_in;
      rsp_live_ff    <= rsp_live_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_id    = rsp_granted_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_retired_count = rsp_retired_ff;
   assign rsp_free_count    = rsp_free_ff;
   assign rsp_live_count    = rsp_live_ff;

endmodule

`default_nettype wire
